@@ rtl/rsf_pkg.sv @@
// rsf_pkg: shared types and constants for the repeat squeeze filter
// used by rsf_front, rsf_queue, rsf_back and the top level
`timescale 1ns / 1ps

package rsf_pkg;

   // work queue between the classifier and the output sequencer
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes on the csr port
   localparam logic [2:0] REG_MODE       = 3'd0;
   localparam logic [2:0] REG_SET_GIVEN  = 3'd1;
   localparam logic [2:0] REG_CHAR_SET_0 = 3'd2;
   localparam logic [2:0] REG_CHAR_SET_1 = 3'd3;
   localparam logic [2:0] REG_CHAR_SET_2 = 3'd4;
   localparam logic [2:0] REG_CHAR_SET_3 = 3'd5;
   localparam logic [2:0] REG_PAIR_LIST  = 3'd6;
   localparam logic [2:0] REG_PAIR_COUNT = 3'd7;

   localparam logic MODE_CHAR = 1'b0;

   // what one queued word makes on the result channel
   typedef enum logic [1:0] {
      KIND_ONE,
      KIND_MARK,
      KIND_TWO
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  first_byte;
      logic [7:0]  last_byte;
      logic        end_flag;
   } work_type;

   typedef struct packed {
      logic         mode;
      logic         set_given;
      logic [255:0] char_set;
      logic [63:0]  pair_list;
      logic [2:0]   pair_count;
   } cfg_type;

endpackage

@@ rtl/rsf_front.sv @@
// rsf_front: accepts string bytes, tracks repeat state and classifies each byte
// depends on rsf_pkg (cfg_type, work_type, kind codes)
`timescale 1ns / 1ps

module rsf_front import rsf_pkg::*; #(
   parameter int PAIR_SLOTS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   input  logic       queue_full,
   output logic       push,
   output work_type   push_word
);

   logic [7:0]  prev_char_ff, prev_char_in;
   logic [15:0] prev_pair_ff, prev_pair_in;
   logic [7:0]  held_ff, held_in;
   logic        odd_ff, odd_in;
   logic        at_start_ff, at_start_in;
   logic        pass_ff, pass_in;

   logic        accept;
   logic [2:0]  eff_count;
   logic [15:0] pair;
   logic        listed;
   logic        char_hit;
   logic        keep_char;
   logic        keep_pair;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign pair      = {held_ff, req_in_byte};
   assign char_hit  = cfg.char_set[req_in_byte];
   assign eff_count = (cfg.pair_count > 3'(PAIR_SLOTS)) ? 3'(PAIR_SLOTS) : cfg.pair_count;

   always_comb begin
      listed = 1'b0;
      for (int i = 0; i < PAIR_SLOTS; i++) begin
         if ((3'(i) < eff_count) && (cfg.pair_list[16*i +: 16] == pair)) begin
            listed = 1'b1;
         end
      end
   end

   assign keep_char = at_start_ff || (req_in_byte != prev_char_ff) ||
                      (cfg.set_given && !char_hit);
   assign keep_pair = at_start_ff || pass_ff || (pair != prev_pair_ff) || !listed;

   always_comb begin
      prev_char_in = prev_char_ff;
      prev_pair_in = prev_pair_ff;
      held_in      = held_ff;
      odd_in       = odd_ff;
      at_start_in  = at_start_ff;
      pass_in      = pass_ff;
      push         = 1'b0;
      push_word.kind       = KIND_ONE;
      push_word.first_byte = held_ff;
      push_word.last_byte  = req_in_byte;
      push_word.end_flag   = req_end_of_string;
      if (accept) begin
         if (cfg.mode == MODE_CHAR) begin
            odd_in      = 1'b0;
            at_start_in = 1'b0;
            if (keep_char) begin
               prev_char_in = req_in_byte;
               push         = 1'b1;
            end else if (req_end_of_string) begin
               push           = 1'b1;
               push_word.kind = KIND_MARK;
            end
         end else if (!odd_ff) begin
            if (at_start_ff) begin
               pass_in = !cfg.set_given || (eff_count == 3'd0);
            end
            if (req_end_of_string) begin
               // lone byte at an even offset closes the string as a trailing byte
               push = 1'b1;
            end else begin
               held_in = req_in_byte;
               odd_in  = 1'b1;
            end
         end else begin
            odd_in       = 1'b0;
            at_start_in  = 1'b0;
            prev_pair_in = pair;
            if (keep_pair) begin
               push           = 1'b1;
               push_word.kind = KIND_TWO;
            end else if (req_end_of_string) begin
               push           = 1'b1;
               push_word.kind = KIND_MARK;
            end
         end
         if (req_end_of_string) begin
            at_start_in = 1'b1;
            odd_in      = 1'b0;
         end
      end
      if (push_word.kind == KIND_MARK) begin
         push_word.last_byte = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_char_ff <= 8'd0;
         prev_pair_ff <= 16'd0;
         held_ff      <= 8'd0;
         odd_ff       <= 1'b0;
         at_start_ff  <= 1'b1;
         pass_ff      <= 1'b0;
      end else begin
         prev_char_ff <= prev_char_in;
         prev_pair_ff <= prev_pair_in;
         held_ff      <= held_in;
         odd_ff       <= odd_in;
         at_start_ff  <= at_start_in;
         pass_ff      <= pass_in;
      end
   end

endmodule

@@ rtl/rsf_queue.sv @@
// rsf_queue: short word queue between the classifier and the output sequencer
// depends on rsf_pkg (work_type, queue sizing)
`timescale 1ns / 1ps

module rsf_queue import rsf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_word,
   input  logic     pop,
   output work_type pop_word,
   output logic     empty,
   output logic     full
);

   work_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign empty    = (count_ff == QCNT_W'(0));
   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/rsf_back.sv @@
// rsf_back: takes queued words and plays them out as one or two results
// depends on rsf_pkg (work_type, kind codes)
`timescale 1ns / 1ps

module rsf_back import rsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  work_type   pop_word,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_out_end,
   output logic       rsp_last_of_item
);

   logic       valid_ff, valid_in;
   logic       pend_ff, pend_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic       pend_end_ff, pend_end_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic       end_ff, end_in;
   logic       last_ff, last_in;
   logic       out_fire;

   assign out_fire = valid_ff && !rsp_stall;

   always_comb begin
      valid_in     = valid_ff;
      pend_in      = pend_ff;
      pend_byte_in = pend_byte_ff;
      pend_end_in  = pend_end_ff;
      byte_in      = byte_ff;
      bvalid_in    = bvalid_ff;
      end_in       = end_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      if (pend_ff) begin
         // second byte of a kept pair follows the first
         if (out_fire) begin
            byte_in   = pend_byte_ff;
            bvalid_in = 1'b1;
            end_in    = pend_end_ff;
            last_in   = 1'b1;
            pend_in   = 1'b0;
         end
      end else if ((!valid_ff || out_fire) && !empty) begin
         pop      = 1'b1;
         valid_in = 1'b1;
         unique case (pop_word.kind)
            KIND_TWO: begin
               byte_in      = pop_word.first_byte;
               bvalid_in    = 1'b1;
               end_in       = 1'b0;
               last_in      = 1'b0;
               pend_in      = 1'b1;
               pend_byte_in = pop_word.last_byte;
               pend_end_in  = pop_word.end_flag;
            end
            KIND_MARK: begin
               byte_in   = 8'd0;
               bvalid_in = 1'b0;
               end_in    = 1'b1;
               last_in   = 1'b1;
            end
            default: begin
               byte_in   = pop_word.last_byte;
               bvalid_in = 1'b1;
               end_in    = pop_word.end_flag;
               last_in   = 1'b1;
            end
         endcase
      end else if (out_fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      pend_end_ff  <= pend_end_in;
      byte_ff      <= byte_in;
      bvalid_ff    <= bvalid_in;
      end_ff       <= end_in;
      last_ff      <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_byte_valid   = bvalid_ff;
   assign rsp_out_end      = end_ff;
   assign rsp_last_of_item = last_ff;

endmodule

@@ rtl/repeat_squeeze_filter.sv @@
// repeat_squeeze_filter: top level with csr registers, classifier, queue and sequencer
// depends on rsf_pkg, rsf_front, rsf_queue, rsf_back
//
// usage:
// - req channel: one string byte per word (req_in_byte, req_end_of_string),
//   taken at a clock edge with req_valid high and req_stall low
// - rsp channel: kept bytes, bare end markers (rsp_byte_valid low) and the
//   per-string end flag; rsp_last_of_item marks the last result of a queued word
// - csr port: 64-bit registers at byte address 8*i, pready always high;
//   write only while the block is idle
// - a result word passes through the queue and the sequencer's output registers before it shows on rsp
// - throughput: one byte per cycle while req_stall is low; the sequencer gives one
//   result per cycle while rsp_stall is low; a kept pair gives one per byte
// - a four-word queue sits between classifier and sequencer; req_stall rises
//   only when it is full, so a stalled receiver backs up into the queue first
// - rsp words hold steady while rsp_stall is high
// - synchronous reset clears the csr registers to zero, empties the queue and
//   puts the filter at the start of a string
`timescale 1ns / 1ps

module repeat_squeeze_filter import rsf_pkg::*; #(
   parameter int PAIR_SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_out_end,
   output logic        rsp_last_of_item,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg_ff;
   logic       csr_write;
   logic [2:0] csr_index;
   logic       queue_full;
   logic       queue_empty;
   logic       push;
   logic       pop;
   work_type   push_word;
   work_type   pop_word;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[5:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MODE:       cfg_ff.mode               <= csr_pwdata[0];
            REG_SET_GIVEN:  cfg_ff.set_given          <= csr_pwdata[0];
            REG_CHAR_SET_0: cfg_ff.char_set[63:0]     <= csr_pwdata;
            REG_CHAR_SET_1: cfg_ff.char_set[127:64]   <= csr_pwdata;
            REG_CHAR_SET_2: cfg_ff.char_set[191:128]  <= csr_pwdata;
            REG_CHAR_SET_3: cfg_ff.char_set[255:192]  <= csr_pwdata;
            REG_PAIR_LIST:  cfg_ff.pair_list          <= csr_pwdata;
            REG_PAIR_COUNT: cfg_ff.pair_count         <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MODE:       csr_prdata = {63'd0, cfg_ff.mode};
         REG_SET_GIVEN:  csr_prdata = {63'd0, cfg_ff.set_given};
         REG_CHAR_SET_0: csr_prdata = cfg_ff.char_set[63:0];
         REG_CHAR_SET_1: csr_prdata = cfg_ff.char_set[127:64];
         REG_CHAR_SET_2: csr_prdata = cfg_ff.char_set[191:128];
         REG_CHAR_SET_3: csr_prdata = cfg_ff.char_set[255:192];
         REG_PAIR_LIST:  csr_prdata = cfg_ff.pair_list;
         REG_PAIR_COUNT: csr_prdata = {61'd0, cfg_ff.pair_count};
         default:        csr_prdata = 64'd0;
      endcase
   end

   rsf_front #(
      .PAIR_SLOTS (PAIR_SLOTS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .queue_full        (queue_full),
      .push              (push),
      .push_word         (push_word)
   );

   rsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   rsf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (queue_empty),
      .pop_word         (pop_word),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_out_end      (rsp_out_end),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule
